>>> sv/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int OUT_W = 13;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } req_ctl_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] lower_y;
    logic signed [OUT_W-1:0] upper_y;
    logic                    last;
  } res_t;

endpackage

>>> sv/mer_front.sv
// Request queue: accepts items, tags them start or step, holds them for the engine.
module mer_front #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   in_mode,
  input  logic [COORD_BITS-1:0]  in_centre_x,
  input  logic [COORD_BITS-1:0]  in_centre_y,
  input  logic [RADIUS_BITS-1:0] in_radius_x,
  input  logic [RADIUS_BITS-1:0] in_radius_y,
  output logic                   full,
  output mer_pkg::req_ctl_t      req_ctl,
  output logic [COORD_BITS-1:0]  req_cx,
  output logic [COORD_BITS-1:0]  req_cy,
  output logic [RADIUS_BITS-1:0] req_rx,
  output logic [RADIUS_BITS-1:0] req_ry,
  input  logic                   req_take
);

  localparam int DEPTH = 2;

  mer_pkg::op_e           op_q [DEPTH];
  logic [COORD_BITS-1:0]  cx_q [DEPTH];
  logic [COORD_BITS-1:0]  cy_q [DEPTH];
  logic [RADIUS_BITS-1:0] rx_q [DEPTH];
  logic [RADIUS_BITS-1:0] ry_q [DEPTH];

  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       wr_en;
  logic       rd_en;

  assign full    = (count_r == 2'(DEPTH));
  assign wr_en   = push && !full;
  assign rd_en   = req_take && (count_r != 2'd0);

  assign req_ctl.valid = (count_r != 2'd0);
  assign req_ctl.op    = op_q[rd_ptr_r];
  assign req_cx        = cx_q[rd_ptr_r];
  assign req_cy        = cy_q[rd_ptr_r];
  assign req_rx        = rx_q[rd_ptr_r];
  assign req_ry        = ry_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_q[wr_ptr_r] <= in_mode ? mer_pkg::OP_STEP : mer_pkg::OP_START;
      cx_q[wr_ptr_r] <= in_centre_x;
      cy_q[wr_ptr_r] <= in_centre_y;
      rx_q[wr_ptr_r] <= in_radius_x;
      ry_q[wr_ptr_r] <= in_radius_y;
    end
  end

endmodule

>>> sv/mer_engine.sv
// Ellipse engine: squared radii, region 1/2 decision updates, point set output.
module mer_engine #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mer_pkg::req_ctl_t      req_ctl,
  input  logic [COORD_BITS-1:0]  req_cx,
  input  logic [COORD_BITS-1:0]  req_cy,
  input  logic [RADIUS_BITS-1:0] req_rx,
  input  logic [RADIUS_BITS-1:0] req_ry,
  output logic                   req_take,
  input  logic                   res_full,
  output logic                   res_push,
  output mer_pkg::res_t          res
);

  localparam int MW    = 2 * RADIUS_BITS + 4;
  localparam int DEC_W = 2 * MW;
  localparam int SW    = 3 * RADIUS_BITS + 3;
  localparam int OW    = RADIUS_BITS + 1;
  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int OUT_W = mer_pkg::OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ENTRY,
    ST_STEP,
    ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [2:0]             cnt_r;
  logic                   busy_r;
  logic                   r2_r;
  logic                   zero_r;
  logic [COORD_BITS-1:0]  cx_r;
  logic [COORD_BITS-1:0]  cy_r;
  logic [RADIUS_BITS-1:0] rx_r;
  logic [RADIUS_BITS-1:0] ry_r;
  logic [SQ_W-1:0]        rx2_r;
  logic [SQ_W-1:0]        ry2_r;
  logic [OW-1:0]          ox_r;
  logic [OW-1:0]          oy_r;
  logic [SW-1:0]          sx_r;
  logic [SW-1:0]          sy_r;
  logic [DEC_W-1:0]       dec_r;
  logic [DEC_W-1:0]       prod_r;
  logic [DEC_W-1:0]       acc_r;
  logic [MW-1:0]          tmp_r;

  logic [MW-1:0]    mul_a;
  logic [MW-1:0]    mul_b;
  logic [DEC_W-1:0] mul_p;

  logic [OW-1:0]    ox_nxt;
  logic [OW-1:0]    oy_nxt;
  logic [SW-1:0]    sx_nxt;
  logic [SW-1:0]    sy_nxt;
  logic [DEC_W-1:0] dec_nxt;

  logic             in_r1;
  logic             need_entry;
  logic             dec_neg;
  logic [SW-1:0]    sx_inc;
  logic [SW-1:0]    sy_dec;
  logic [DEC_W-1:0] rx2_e;
  logic [DEC_W-1:0] ry2_e;
  logic [OW+1:0]    tx;
  logic [OW-1:0]    ty;

  assign rx2_e      = DEC_W'(rx2_r);
  assign ry2_e      = DEC_W'(ry2_r);
  assign dec_neg    = dec_r[DEC_W-1];
  assign in_r1      = !r2_r && (sx_r <= sy_r);
  assign need_entry = !r2_r && !(sx_r <= sy_r);
  assign sx_inc     = sx_r + SW'({ry2_r, 1'b0});
  assign sy_dec     = sy_r - SW'({rx2_r, 1'b0});
  assign tx         = {1'b0, ox_r, 1'b1};
  assign ty         = oy_r - OW'(1);

  // one shared multiplier, operands picked by sequence step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_START: begin
        unique case (cnt_r)
          3'd0: begin mul_a = MW'(ry_r);  mul_b = MW'(ry_r); end
          3'd1: begin mul_a = MW'(rx_r);  mul_b = MW'(rx_r); end
          3'd2: begin mul_a = prod_r[MW-1:0]; mul_b = MW'(ry_r); end
          default: ;
        endcase
      end
      ST_ENTRY: begin
        unique case (cnt_r)
          3'd0: begin mul_a = MW'(tx);    mul_b = MW'(tx); end
          3'd1: begin mul_a = MW'(ty);    mul_b = MW'(ty); end
          3'd2: begin mul_a = MW'(ry2_r); mul_b = tmp_r; end
          3'd3: begin mul_a = MW'(rx2_r); mul_b = tmp_r; end
          3'd4: begin mul_a = MW'(rx2_r); mul_b = MW'(ry2_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one incremental step of whichever region is active
  always_comb begin
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    dec_nxt = dec_r;
    if (in_r1) begin
      ox_nxt = ox_r + OW'(1);
      sx_nxt = sx_inc;
      if (dec_neg) begin
        dec_nxt = dec_r + ((DEC_W'(sx_inc) + ry2_e) << 2);
      end else begin
        oy_nxt  = oy_r - OW'(1);
        sy_nxt  = sy_dec;
        dec_nxt = dec_r + ((DEC_W'(sx_inc) - DEC_W'(sy_dec) + ry2_e) << 2);
      end
    end else begin
      oy_nxt = oy_r - OW'(1);
      sy_nxt = sy_dec;
      if (!dec_neg && (dec_r != '0)) begin
        dec_nxt = dec_r + ((rx2_e - DEC_W'(sy_dec)) << 2);
      end else begin
        ox_nxt  = ox_r + OW'(1);
        sx_nxt  = sx_inc;
        dec_nxt = dec_r + ((DEC_W'(sx_inc) - DEC_W'(sy_dec) + rx2_e) << 2);
      end
    end
  end

  assign req_take = (state_r == ST_IDLE) && req_ctl.valid;
  assign res_push = (state_r == ST_EMIT) && !res_full;

  always_comb begin
    res.valid_res = !zero_r;
    res.right_x   = '0;
    res.left_x    = '0;
    res.lower_y   = '0;
    res.upper_y   = '0;
    res.last      = 1'b0;
    if (!zero_r) begin
      res.right_x = OUT_W'(cx_r) + OUT_W'(ox_r);
      res.left_x  = OUT_W'(cx_r) - OUT_W'(ox_r);
      res.lower_y = OUT_W'(cy_r) + OUT_W'(oy_r);
      res.upper_y = OUT_W'(cy_r) - OUT_W'(oy_r);
      res.last    = (oy_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 3'd0;
      busy_r  <= 1'b0;
      r2_r    <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_ctl.valid) begin
            priority if (req_ctl.op == mer_pkg::OP_START) begin
              cx_r    <= req_cx;
              cy_r    <= req_cy;
              rx_r    <= req_rx;
              ry_r    <= req_ry;
              cnt_r   <= 3'd0;
              state_r <= ST_START;
            end else if (!busy_r) begin
              zero_r  <= 1'b1;
              state_r <= ST_EMIT;
            end else if (need_entry) begin
              cnt_r   <= 3'd0;
              state_r <= ST_ENTRY;
            end else begin
              ox_r    <= ox_nxt;
              oy_r    <= oy_nxt;
              sx_r    <= sx_nxt;
              sy_r    <= sy_nxt;
              dec_r   <= dec_nxt;
              busy_r  <= (oy_nxt != '0);
              zero_r  <= 1'b0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_START: begin
          cnt_r <= cnt_r + 3'd1;
          unique case (cnt_r)
            3'd1: ry2_r <= prod_r[SQ_W-1:0];
            3'd2: rx2_r <= prod_r[SQ_W-1:0];
            3'd3: begin
              // prod_r holds rx^2 * ry here
              sy_r    <= SW'(prod_r << 1);
              dec_r   <= (ry2_e << 2) - (prod_r << 2) + rx2_e;
              sx_r    <= '0;
              ox_r    <= '0;
              oy_r    <= OW'(ry_r);
              r2_r    <= 1'b0;
              busy_r  <= (ry_r != '0);
              zero_r  <= 1'b0;
              state_r <= ST_EMIT;
            end
            default: ;
          endcase
        end
        ST_ENTRY: begin
          cnt_r <= cnt_r + 3'd1;
          unique case (cnt_r)
            3'd1: tmp_r <= prod_r[MW-1:0];
            3'd2: tmp_r <= prod_r[MW-1:0];
            3'd3: acc_r <= prod_r;
            3'd4: acc_r <= acc_r + (prod_r << 2);
            3'd5: begin
              dec_r   <= acc_r - (prod_r << 2);
              r2_r    <= 1'b1;
              state_r <= ST_STEP;
            end
            default: ;
          endcase
        end
        ST_STEP: begin
          ox_r    <= ox_nxt;
          oy_r    <= oy_nxt;
          sx_r    <= sx_nxt;
          sy_r    <= sy_nxt;
          dec_r   <= dec_nxt;
          busy_r  <= (oy_nxt != '0);
          zero_r  <= 1'b0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/mer_outq.sv
// Two-entry result queue in front of the out_ ports.
module mer_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  mer_pkg::res_t res,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output mer_pkg::res_t head
);

  localparam int DEPTH = 2;

  mer_pkg::res_t q [DEPTH];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          wr_en;
  logic          rd_en;

  assign res_full = (count_r == 2'(DEPTH));
  assign empty    = (count_r == 2'd0);
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;
  assign head     = q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr_r] <= res;
    end
  end

endmodule

>>> sv/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level.
// Usage: each request on the in_ side (push/full) gives exactly one result on
// the out_ side (empty/pop), in request order. A request is taken when push is
// high and full is low; a result leaves when pop is high and empty is low.
// in_mode = 0 starts an ellipse (centre and radii) and returns the point set at
// offset (0, ry); in_mode = 1 advances one pixel and returns four mirrored
// coordinates. A step with no ellipse running returns out_valid_res = 0 and
// zero coordinates. out_last marks the point set where y reaches 0.
// Flow: a request waits in a two-entry request queue, then the engine works
// on it alone. A start makes three passes through the shared multiplier, and
// the step that leaves region 1 makes five multiplier passes to form the
// region 2 decision. The engine's result is registered in the result queue
// before it appears on the ports.
// A two-entry result queue decouples the receiver: a stalled pop holds the
// oldest result on the ports while the engine and request queue keep going
// until both queues fill. Synchronous reset empties both queues and idles the
// engine.
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_mode,
  input  logic [COORD_BITS-1:0]               in_centre_x,
  input  logic [COORD_BITS-1:0]               in_centre_y,
  input  logic [RADIUS_BITS-1:0]              in_radius_x,
  input  logic [RADIUS_BITS-1:0]              in_radius_y,
  output logic                                empty,
  input  logic                                pop,
  output logic                                out_valid_res,
  output logic signed [mer_pkg::OUT_W-1:0]    out_right_x,
  output logic signed [mer_pkg::OUT_W-1:0]    out_left_x,
  output logic signed [mer_pkg::OUT_W-1:0]    out_lower_y,
  output logic signed [mer_pkg::OUT_W-1:0]    out_upper_y,
  output logic                                out_last
);

  mer_pkg::req_ctl_t      req_ctl;
  logic [COORD_BITS-1:0]  req_cx;
  logic [COORD_BITS-1:0]  req_cy;
  logic [RADIUS_BITS-1:0] req_rx;
  logic [RADIUS_BITS-1:0] req_ry;
  logic                   req_take;
  logic                   res_full;
  logic                   res_push;
  mer_pkg::res_t          res;
  mer_pkg::res_t          head;

  mer_front #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_mode    (in_mode),
    .in_centre_x(in_centre_x),
    .in_centre_y(in_centre_y),
    .in_radius_x(in_radius_x),
    .in_radius_y(in_radius_y),
    .full       (full),
    .req_ctl    (req_ctl),
    .req_cx     (req_cx),
    .req_cy     (req_cy),
    .req_rx     (req_rx),
    .req_ry     (req_ry),
    .req_take   (req_take)
  );

  mer_engine #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_ctl (req_ctl),
    .req_cx  (req_cx),
    .req_cy  (req_cy),
    .req_rx  (req_rx),
    .req_ry  (req_ry),
    .req_take(req_take),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  mer_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_push(res_push),
    .res     (res),
    .res_full(res_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign out_valid_res = head.valid_res;
  assign out_right_x   = head.right_x;
  assign out_left_x    = head.left_x;
  assign out_lower_y   = head.lower_y;
  assign out_upper_y   = head.upper_y;
  assign out_last      = head.last;

endmodule

>>> sv/mer_checker.sv
// Port-level checks for the rasterizer, bound to the top level.
module mer_checker #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             push,
  input logic                             full,
  input logic                             in_mode,
  input logic [COORD_BITS-1:0]            in_centre_x,
  input logic [COORD_BITS-1:0]            in_centre_y,
  input logic [RADIUS_BITS-1:0]           in_radius_x,
  input logic [RADIUS_BITS-1:0]           in_radius_y,
  input logic                             empty,
  input logic                             pop,
  input logic                             out_valid_res,
  input logic signed [mer_pkg::OUT_W-1:0] out_right_x,
  input logic signed [mer_pkg::OUT_W-1:0] out_left_x,
  input logic signed [mer_pkg::OUT_W-1:0] out_lower_y,
  input logic signed [mer_pkg::OUT_W-1:0] out_upper_y,
  input logic                             out_last
);

  // reset leaves no results and room for requests
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // a request held off by full stays put until taken
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> (push && $stable(in_mode) && $stable(in_centre_x)
                        && $stable(in_centre_y) && $stable(in_radius_x)
                        && $stable(in_radius_y)))
    else $error("stalled request changed");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_right_x) && $stable(out_left_x)
                          && $stable(out_lower_y) && $stable(out_upper_y)
                          && $stable(out_valid_res) && $stable(out_last)))
    else $error("stalled result changed");

  // idle step result carries no coordinates
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid_res) |-> (out_right_x == '0 && out_left_x == '0
                                     && out_lower_y == '0 && out_upper_y == '0
                                     && !out_last))
    else $error("invalid result with nonzero fields");

  // last point set sits on the centre row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_lower_y == out_upper_y && out_valid_res))
    else $error("last point set off the centre row");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
  .RADIUS_BITS(RADIUS_BITS),
  .COORD_BITS (COORD_BITS)
) u_mer_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for midpoint_ellipse_rasterizer: directed table, then random ellipses.
`timescale 1ns / 100ps

module tb_top;

  localparam int RB         = 10;
  localparam int CB         = 11;
  localparam int RAND_ITEMS = 1850;

  typedef struct {
    mer_pkg::op_e  op;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [RB-1:0] rx;
    logic [RB-1:0] ry;
    bit            typed;
    mer_pkg::res_t want;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             push;
  logic                             full;
  logic                             in_mode;
  logic [CB-1:0]                    in_centre_x;
  logic [CB-1:0]                    in_centre_y;
  logic [RB-1:0]                    in_radius_x;
  logic [RB-1:0]                    in_radius_y;
  logic                             empty;
  logic                             pop;
  logic                             out_valid_res;
  logic signed [mer_pkg::OUT_W-1:0] out_right_x;
  logic signed [mer_pkg::OUT_W-1:0] out_left_x;
  logic signed [mer_pkg::OUT_W-1:0] out_lower_y;
  logic signed [mer_pkg::OUT_W-1:0] out_upper_y;
  logic                             out_last;

  // point sets still owed by the block, oldest first
  mer_pkg::res_t pending_pts[$];
  stim_row_t     script[$];
  int            errs;
  int            got_cnt;
  int            drawn;
  int            send_idle;
  int            recv_idle;

  // predicted rasterizer state
  logic [CB-1:0] ctr_col;
  logic [CB-1:0] ctr_row;
  logic [63:0]   rx2;
  logic [63:0]   ry2;
  logic [RB:0]   px;
  logic [RB-1:0] py;
  logic [63:0]   dval;
  logic [63:0]   grad_x;
  logic [63:0]   grad_y;
  bit            in_r2;
  bit            drawing;

  midpoint_ellipse_rasterizer #(
    .RADIUS_BITS(RB),
    .COORD_BITS (CB)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_centre_x  (in_centre_x),
    .in_centre_y  (in_centre_y),
    .in_radius_x  (in_radius_x),
    .in_radius_y  (in_radius_y),
    .empty        (empty),
    .pop          (pop),
    .out_valid_res(out_valid_res),
    .out_right_x  (out_right_x),
    .out_left_x   (out_left_x),
    .out_lower_y  (out_lower_y),
    .out_upper_y  (out_upper_y),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** midpoint_ellipse_rasterizer: FAILED **");
    $finish;
  end

  function automatic mer_pkg::res_t plot_set(input bit fin);
    mer_pkg::res_t r;
    r.valid_res = 1'b1;
    r.right_x   = {2'b00, ctr_col} + {2'b00, px};
    r.left_x    = {2'b00, ctr_col} - {2'b00, px};
    r.lower_y   = {2'b00, ctr_row} + {3'b000, py};
    r.upper_y   = {2'b00, ctr_row} - {3'b000, py};
    r.last      = fin;
    return r;
  endfunction

  // Advance the predicted rasterizer by one request and return its point set.
  function automatic mer_pkg::res_t trace_ellipse(input mer_pkg::op_e op,
                                                  input logic [CB-1:0] cx,
                                                  input logic [CB-1:0] cy,
                                                  input logic [RB-1:0] rx,
                                                  input logic [RB-1:0] ry);
    logic [63:0] rxw;
    logic [63:0] ryw;
    logic [63:0] tx;
    logic [63:0] ty;
    bit          neg;
    bit          pos;
    rxw = {{(64-RB){1'b0}}, rx};
    ryw = {{(64-RB){1'b0}}, ry};
    if (op == mer_pkg::OP_START) begin
      ctr_col = cx;
      ctr_row = cy;
      rx2     = rxw * rxw;
      ry2     = ryw * ryw;
      px      = '0;
      py      = ry;
      grad_x  = '0;
      grad_y  = 64'd2 * rx2 * ryw;
      // 4 * (ry^2 - rx^2*ry + rx^2/4)
      dval    = 64'd4 * ry2 - 64'd4 * rx2 * ryw + rx2;
      in_r2   = 1'b0;
      drawing = (ry != '0);
      return plot_set(ry == '0);
    end
    if (!drawing)
      return '0;
    if (!in_r2 && grad_x <= grad_y) begin
      neg    = dval[63];
      px     = px + 1'b1;
      grad_x = grad_x + 64'd2 * ry2;
      if (neg) begin
        dval = dval + 64'd4 * (grad_x + ry2);
      end else begin
        py     = py - 1'b1;
        grad_y = grad_y - 64'd2 * rx2;
        dval   = dval + 64'd4 * (grad_x - grad_y + ry2);
      end
    end else begin
      if (!in_r2) begin
        // region 2 decision from (x + 0.5, y - 1), scaled by 4
        tx    = 64'd2 * {{(63-RB){1'b0}}, px} + 64'd1;
        ty    = {{(64-RB){1'b0}}, py} - 64'd1;
        dval  = ry2 * tx * tx + 64'd4 * rx2 * ty * ty - 64'd4 * rx2 * ry2;
        in_r2 = 1'b1;
      end
      pos    = !dval[63] && (dval != '0);
      py     = py - 1'b1;
      grad_y = grad_y - 64'd2 * rx2;
      if (pos) begin
        dval = dval + 64'd4 * (rx2 - grad_y);
      end else begin
        px     = px + 1'b1;
        grad_x = grad_x + 64'd2 * ry2;
        dval   = dval + 64'd4 * (grad_x - grad_y + rx2);
      end
    end
    if (py == '0)
      drawing = 1'b0;
    return plot_set(py == '0);
  endfunction

  function automatic stim_row_t row(input mer_pkg::op_e op, input int cx, input int cy,
                                    input int rx, input int ry, input bit typed,
                                    input mer_pkg::res_t want);
    stim_row_t s;
    s.op    = op;
    s.cx    = cx[CB-1:0];
    s.cy    = cy[CB-1:0];
    s.rx    = rx[RB-1:0];
    s.ry    = ry[RB-1:0];
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  task automatic flag(input string what, input longint got, input longint want);
    errs++;
    if (errs <= 40)
      $display("mismatch at %0t, result %0d, %s: got %0d expected %0d",
               $time, got_cnt, what, got, want);
  endtask

  task automatic check_point_set();
    mer_pkg::res_t got;
    mer_pkg::res_t want;
    got = {out_valid_res, out_right_x, out_left_x, out_lower_y, out_upper_y, out_last};
    if (pending_pts.size() == 0) begin
      flag("result with nothing outstanding", 0, 0);
      return;
    end
    want = pending_pts.pop_front();
    if (got.valid_res !== want.valid_res) flag("valid_res", got.valid_res, want.valid_res);
    if (got.right_x !== want.right_x) flag("right_x", got.right_x, want.right_x);
    if (got.left_x !== want.left_x) flag("left_x", got.left_x, want.left_x);
    if (got.lower_y !== want.lower_y) flag("lower_y", got.lower_y, want.lower_y);
    if (got.upper_y !== want.upper_y) flag("upper_y", got.upper_y, want.upper_y);
    if (got.last !== want.last) flag("last", got.last, want.last);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer(input mer_pkg::op_e op, input logic [CB-1:0] cx,
                       input logic [CB-1:0] cy, input logic [RB-1:0] rx,
                       input logic [RB-1:0] ry, input bit typed,
                       input mer_pkg::res_t want);
    mer_pkg::res_t pred;
    bit            live;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push        <= 1'b1;
    in_mode     <= op;
    in_centre_x <= cx;
    in_centre_y <= cy;
    in_radius_x <= rx;
    in_radius_y <= ry;
    @(posedge clk);
    while (full) @(posedge clk);
    live = (op == mer_pkg::OP_START) || drawing;
    pred = trace_ellipse(op, cx, cy, rx, ry);
    pending_pts.push_back(typed ? want : pred);
    if (live)
      drawn++;
    @(negedge clk);
  endtask

  task automatic step_once();
    offer(mer_pkg::OP_STEP, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom),
          1'b0, '0);
  endtask

  task automatic start_ellipse(input int rx, input int ry);
    offer(mer_pkg::OP_START, CB'($urandom_range(2047)), CB'($urandom_range(2047)),
          RB'(rx), RB'(ry), 1'b0, '0);
  endtask

  // hold off the sender until every outstanding point set has come back
  task automatic drain_pause();
    push <= 1'b0;
    do @(negedge clk); while (pending_pts.size() != 0);
  endtask

  // request side
  initial begin
    int            k;
    int            kind;
    int            phase;
    mer_pkg::res_t idle;
    rst_n       = 1'b0;
    push        = 1'b0;
    in_mode     = mer_pkg::OP_START;
    in_centre_x = '0;
    in_centre_y = '0;
    in_radius_x = '0;
    in_radius_y = '0;
    errs        = 0;
    drawn       = 0;
    send_idle   = 18;
    recv_idle   = 64;
    phase       = 0;
    idle        = '0;
    ctr_col = '0; ctr_row = '0; rx2 = '0; ry2 = '0; px = '0; py = '0;
    dval = '0; grad_x = '0; grad_y = '0; in_r2 = 1'b0; drawing = 1'b0;

    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b1, idle));
    // zero vertical radius: single point set, flagged last
    script.push_back(row(mer_pkg::OP_START, 0, 0, 1, 0, 1'b1,
                         mer_pkg::res_t'{1'b1, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 1'b1}));
    script.push_back(row(mer_pkg::OP_STEP, 2047, 2047, 1023, 1023, 1'b1, idle));
    script.push_back(row(mer_pkg::OP_START, 2047, 2047, 1023, 1023, 1'b1,
                         mer_pkg::res_t'{1'b1, 13'sd2047, 13'sd2047, 13'sd3070, 13'sd1024,
                                         1'b0}));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    // start while busy, most negative row
    script.push_back(row(mer_pkg::OP_START, 0, 0, 1023, 1023, 1'b1,
                         mer_pkg::res_t'{1'b1, 13'sd0, 13'sd0, 13'sd1023, -13'sd1023,
                                         1'b0}));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    // zero horizontal radius, run to the end and one step past it
    script.push_back(row(mer_pkg::OP_START, 100, 100, 0, 3, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_START, 1000, 20, 1, 1, 1'b1,
                         mer_pkg::res_t'{1'b1, 13'sd1000, 13'sd1000, 13'sd21, 13'sd19,
                                         1'b0}));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    // flat ellipse: a start and two steps, all in region 1
    script.push_back(row(mer_pkg::OP_START, 500, 500, 40, 1, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_START, 600, 600, 5, 3, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_START, 600, 600, 3, 5, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_START, 10, 5, 2, 1023, 1'b0, idle));
    script.push_back(row(mer_pkg::OP_STEP, 0, 0, 0, 0, 1'b0, idle));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      offer(script[i].op, script[i].cx, script[i].cy, script[i].rx, script[i].ry,
            script[i].typed, script[i].want);
    drain_pause();

    drawn = 0;
    while (drawn < RAND_ITEMS) begin
      if (phase == 0 && drawn >= 600) begin
        drain_pause();
        send_idle = 64;
        recv_idle = 18;
        phase     = 1;
      end else if (phase == 1 && drawn >= 1200) begin
        drain_pause();
        send_idle = 0;
        recv_idle = 0;
        phase     = 2;
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        start_ellipse($urandom_range(48), $urandom_range(48));
        while (drawing) step_once();
        if ($urandom_range(3) == 0)
          step_once();
      end else if (kind < 76) begin
        start_ellipse($urandom_range(200, 49), $urandom_range(200, 49));
        while (drawing) step_once();
      end else if (kind < 90) begin
        // large radii, dropped partway by the next start
        start_ellipse($urandom_range(1023), $urandom_range(1023));
        k = $urandom_range(30);
        while (k > 0 && drawing) begin
          step_once();
          k--;
        end
      end else begin
        for (k = $urandom_range(4, 1); k > 0; k--)
          offer(mer_pkg::op_e'($urandom_range(1)), CB'($urandom), CB'($urandom),
                RB'($urandom), RB'($urandom), 1'b0, '0);
      end
    end

    push <= 1'b0;
    for (k = 0; k < 200000 && pending_pts.size() != 0; k++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_pts.size() != 0)
      flag("point sets never returned", pending_pts.size(), 0);
    if (errs == 0)
      $display("** midpoint_ellipse_rasterizer: PASSED **");
    else
      $display("** midpoint_ellipse_rasterizer: FAILED **");
    $finish;
  end

  // result side
  initial begin
    int hold_left;
    hold_left = 0;
    got_cnt   = 0;
    pop       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
      @(posedge clk);
      if (pop && !empty) begin
        check_point_set();
        got_cnt++;
        // long stall so both queues fill and full backs up the sender
        if (got_cnt == 300 || got_cnt == 1500)
          hold_left = 150;
      end
    end
  end

endmodule

>>> sim.f
sv/mer_pkg.sv
sv/mer_front.sv
sv/mer_engine.sv
sv/mer_outq.sv
sv/midpoint_ellipse_rasterizer.sv
sv/mer_checker.sv
sim/tb_top.sv
